// ----- hw/rtl/qdsm_pkg.sv -----
// Shared types and constants for the quadrature decoder / speed meter.
// Used by qdsm_div and quadrature_decoder_speed_meter_core; no dependencies.

package qdsm_pkg;

    // divider operand widths: |count| (16b) times scale (32b) over elapsed (32b)
    localparam int DIV_DW = 48;
    localparam int DIV_SW = 32;
    localparam int DIV_CW = $clog2(DIV_DW + 1);

    // moving-average depth; a power of two so the mean is an arithmetic shift
    localparam int AVERAGE_DEPTH = 4;
    localparam int AVG_SHIFT     = $clog2(AVERAGE_DEPTH);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 1'b1;

    // input word kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
    localparam logic [31:0] SPEED_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] SPEED_MIN   = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_MUL,
        S_DIV_RAW,
        S_DIV_RAW_WAIT,
        S_SAT,
        S_HIST,
        S_SUM,
        S_AVG,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hw/rtl/qdsm_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle (48 / 32 bits).
// Depends on qdsm_pkg for widths and the request/response structs.

module qdsm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  qdsm_pkg::div_req_t req,
    output qdsm_pkg::div_rsp_t rsp
);

    logic [qdsm_pkg::DIV_CW-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [qdsm_pkg::DIV_SW-1:0] rem_reg;
    logic [qdsm_pkg::DIV_DW-1:0] work_reg;
    logic [qdsm_pkg::DIV_SW-1:0] dvs_reg;

    logic [qdsm_pkg::DIV_SW:0]   trial;
    logic                        fits;
    logic [qdsm_pkg::DIV_SW-1:0] rem_next;
    logic [qdsm_pkg::DIV_DW-1:0] work_next;

    always_comb
    begin
        trial     = {rem_reg, work_reg[qdsm_pkg::DIV_DW-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_next  = fits ? qdsm_pkg::DIV_SW'(trial - {1'b0, dvs_reg})
                         : trial[qdsm_pkg::DIV_SW-1:0];
        work_next = {work_reg[qdsm_pkg::DIV_DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= qdsm_pkg::DIV_CW'(qdsm_pkg::DIV_DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == qdsm_pkg::DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            work_reg <= req.dividend;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = work_reg;

endmodule

// ----- hw/rtl/quadrature_decoder_speed_meter_core.sv -----
// Quadrature x4 decoder with M/T speed meter and moving-average filter.
// Depends on qdsm_pkg and qdsm_div (serial divider).
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    kind, a_changed, b_changed, level_a, level_b, now_us
//   out      out  out_valid/out_ready  speed, pending_count
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
// Edge word: idle accepts it and goes straight to emit, which loads the output register.
// Tick with zero count or zero elapsed time: tick, then emit with a zero speed.
// Tick with a nonzero count: tick, mul, div_raw, div_raw_wait, sat, hist, sum, avg, emit;
// the 48-step divider gives the raw speed; the mean over the history is a shift.
// in_ready is high only in idle; a result sits in the output register until taken,
// and a new word may be accepted meanwhile; the next result then waits in emit.
// Reset clears count, times, history, running sum and config to reset values.

module quadrature_decoder_speed_meter_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic                           a_changed,
    input  logic                           b_changed,
    input  logic                           level_a,
    input  logic                           level_b,
    input  logic [31:0]                    now_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             speed,
    output logic signed [31:0]             pending_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qdsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int SLOT_W = qdsm_pkg::AVG_SHIFT;
    localparam int SUM_W  = 32 + qdsm_pkg::AVG_SHIFT;

    qdsm_pkg::state_t   state_reg, state_next;
    qdsm_pkg::div_req_t div_req;
    qdsm_pkg::div_rsp_t div_rsp;

    logic [31:0]       edge_count_reg;
    logic [31:0]       latest_reg;
    logic [31:0]       prev_reg;
    logic [31:0]       hist_reg [qdsm_pkg::AVERAGE_DEPTH];
    logic [SLOT_W-1:0] slot_reg;
    logic [31:0]       cur_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [31:0]       scale_reg;
    logic              invert_reg;
    logic              out_valid_reg;
    logic [31:0]       out_speed_reg;
    logic [31:0]       out_count_reg;

    // working registers of one tick
    logic [31:0]       now_reg;
    logic              neg_reg;
    logic [15:0]       mag_reg;
    logic [31:0]       elapsed_reg;
    logic [47:0]       prod_reg;
    logic [31:0]       raw_reg;

    logic              in_fire;
    logic              out_free;
    logic [15:0]       taken;
    logic [31:0]       tick_elapsed;
    logic [31:0]       edge_delta;
    logic [31:0]       raw_sat;
    logic signed [SUM_W-1:0] avg_shr;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign taken        = edge_count_reg[15:0];
    assign tick_elapsed = latest_reg - prev_reg;

    // x4 decode: each changed phase is worth +1 or -1
    always_comb
    begin
        edge_delta = '0;
        if (a_changed)
            edge_delta = (level_a != level_b) ? 32'd1 : 32'hFFFF_FFFF;
        if (b_changed)
            edge_delta = edge_delta + ((level_a == level_b) ? 32'd1 : 32'hFFFF_FFFF);
    end

    always_comb
    begin
        if (neg_reg)
            raw_sat = (|div_rsp.quotient[47:31]) ? qdsm_pkg::SPEED_MIN
                                                 : 32'(-div_rsp.quotient[31:0]);
        else
            raw_sat = (|div_rsp.quotient[47:31]) ? qdsm_pkg::SPEED_MAX
                                                 : div_rsp.quotient[31:0];
        if (invert_reg)
            raw_sat = (raw_sat == qdsm_pkg::SPEED_MIN) ? qdsm_pkg::SPEED_MAX
                                                       : 32'(-raw_sat);
    end

    // arithmetic shift rounds the mean toward minus infinity
    assign avg_shr = $signed(sum_reg) >>> qdsm_pkg::AVG_SHIFT;

    qdsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qdsm_pkg::S_IDLE:
                if (in_fire)
                    state_next = (kind == qdsm_pkg::KIND_TICK) ? qdsm_pkg::S_TICK
                                                               : qdsm_pkg::S_EMIT;
            qdsm_pkg::S_TICK:
                if (taken == '0 || tick_elapsed == '0)
                    state_next = qdsm_pkg::S_EMIT;
                else
                    state_next = qdsm_pkg::S_MUL;
            qdsm_pkg::S_MUL:        state_next = qdsm_pkg::S_DIV_RAW;
            qdsm_pkg::S_DIV_RAW:    state_next = qdsm_pkg::S_DIV_RAW_WAIT;
            qdsm_pkg::S_DIV_RAW_WAIT:
                if (div_rsp.done)
                    state_next = qdsm_pkg::S_SAT;
            qdsm_pkg::S_SAT:        state_next = qdsm_pkg::S_HIST;
            qdsm_pkg::S_HIST:       state_next = qdsm_pkg::S_SUM;
            qdsm_pkg::S_SUM:        state_next = qdsm_pkg::S_AVG;
            qdsm_pkg::S_AVG:        state_next = qdsm_pkg::S_EMIT;
            qdsm_pkg::S_EMIT:
                if (out_free)
                    state_next = qdsm_pkg::S_IDLE;
            default:                state_next = qdsm_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready             = 1'b0;
        div_req.start        = 1'b0;
        div_req.dividend     = prod_reg;
        div_req.divisor      = elapsed_reg;
        case (state_reg)
            qdsm_pkg::S_IDLE:
                in_ready = 1'b1;
            qdsm_pkg::S_DIV_RAW:
                div_req.start = 1'b1;
            default:
            begin
                in_ready      = 1'b0;
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qdsm_pkg::S_IDLE;
            edge_count_reg <= '0;
            latest_reg     <= '0;
            prev_reg       <= '0;
            for (int i = 0; i < qdsm_pkg::AVERAGE_DEPTH; i++)
                hist_reg[i] <= '0;
            slot_reg       <= '0;
            cur_reg        <= '0;
            sum_reg        <= '0;
            scale_reg      <= qdsm_pkg::SCALE_RESET;
            invert_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == qdsm_pkg::CFG_SPEED_SCALE)
                    scale_reg <= cfg_data;
                else if (cfg_index == qdsm_pkg::CFG_INVERT)
                    invert_reg <= cfg_data[0];
            end

            if (state_reg == qdsm_pkg::S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                qdsm_pkg::S_IDLE:
                    if (in_fire && kind == qdsm_pkg::KIND_EDGE)
                    begin
                        edge_count_reg <= edge_count_reg + edge_delta;
                        if (a_changed || b_changed)
                            latest_reg <= now_us;
                    end
                qdsm_pkg::S_TICK:
                begin
                    edge_count_reg <= '0;
                    if (taken == '0)
                    begin
                        cur_reg  <= '0;
                        prev_reg <= now_reg;
                    end
                    else
                    begin
                        prev_reg <= latest_reg;
                        if (tick_elapsed == '0)
                            cur_reg <= '0;
                    end
                end
                qdsm_pkg::S_HIST:
                begin
                    sum_reg <= sum_reg - {{(SUM_W-32){hist_reg[slot_reg][31]}},
                                          hist_reg[slot_reg]};
                    hist_reg[slot_reg] <= raw_reg;
                    slot_reg <= (slot_reg == SLOT_W'(qdsm_pkg::AVERAGE_DEPTH - 1)) ? '0
                                                                   : slot_reg + 1'b1;
                end
                qdsm_pkg::S_SUM:
                    sum_reg <= sum_reg + {{(SUM_W-32){raw_reg[31]}}, raw_reg};
                qdsm_pkg::S_AVG:
                    cur_reg <= avg_shr[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            now_reg <= now_us;
        if (state_reg == qdsm_pkg::S_TICK)
        begin
            elapsed_reg <= tick_elapsed;
            neg_reg     <= taken[15];
            mag_reg     <= taken[15] ? 16'(-taken) : taken;
        end
        if (state_reg == qdsm_pkg::S_MUL)
            prod_reg <= mag_reg * scale_reg;
        if (state_reg == qdsm_pkg::S_SAT)
            raw_reg <= raw_sat;
        if (state_reg == qdsm_pkg::S_EMIT && out_free)
        begin
            out_speed_reg <= cur_reg;
            out_count_reg <= edge_count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign speed         = out_speed_reg;
    assign pending_count = out_count_reg;

    // the divider only answers while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == qdsm_pkg::S_DIV_RAW_WAIT))
        else $error("divider done outside a wait state");

    // a result appears only from the emit step
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == qdsm_pkg::S_EMIT))
        else $error("output valid without emit");

    // a tick always leaves a cleared count behind
    a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qdsm_pkg::S_TICK |=> edge_count_reg == '0)
        else $error("count not cleared by tick");

    // history slot stays inside the filter depth
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(qdsm_pkg::AVERAGE_DEPTH - 1))
        else $error("history slot out of range");

    // divider start never held high twice in a row
    a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_req.start)
        else $error("divider started twice in a row");

endmodule
